@@ sv/mdm_pkg.sv @@
package mdm_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DIM_W = $clog2((MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS) + 1);

    localparam int CFG_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int KIND_W = 2;
    localparam int COL_W = 6;
    localparam int ROW_W = 6;
    localparam int DIST_W = 8;
    localparam int DIST_MAX = (1 << DIST_W) - 1;

    localparam logic [CFG_W-1:0] GRID_WIDTH_RST = 7'd16;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_PLACE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_PLACE,
        ST_READ,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_FILL,
        SW_PLACE
    } sweep_mode_t;

    typedef struct packed {
        logic        accept;
        logic        step;
        sweep_mode_t mode;
        logic        read;
        logic        load;
    } mdm_cmd_t;

    typedef struct packed {
        logic grid_empty;
        logic in_grid;
        logic last_cell;
        logic out_free;
    } mdm_status_t;

    function automatic logic [DIM_W-1:0] used_dim(input logic [CFG_W-1:0] v,
                                                  input int unsigned lim);
        logic [DIM_W-1:0] res;
        if (32'(v) > lim)
        begin
            res = DIM_W'(lim);
        end
        else
        begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    function automatic logic [DIST_W-1:0] fill_value(input logic [DIM_W-1:0] w,
                                                     input logic [DIM_W-1:0] h);
        logic [DIM_W+1:0] sum;
        logic [DIST_W-1:0] res;
        sum = (DIM_W+2)'(w) + (DIM_W+2)'(h) + (DIM_W+2)'(1);
        if (32'(sum) > DIST_MAX)
        begin
            res = DIST_W'(DIST_MAX);
        end
        else
        begin
            res = DIST_W'(sum);
        end
        return res;
    endfunction

    localparam logic [DIST_W-1:0] RESET_FILL =
        fill_value(used_dim(GRID_WIDTH_RST, MAX_COLS), used_dim(GRID_HEIGHT_RST, MAX_ROWS));

endpackage

@@ sv/mdm_item_if.sv @@
interface mdm_item_if
    import mdm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;

    modport source (output valid, output kind, output col, output row, input ready);
    modport sink (input valid, input kind, input col, input row, output ready);
endinterface

@@ sv/mdm_result_if.sv @@
interface mdm_result_if
    import mdm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              out_of_range;

    modport source (output valid, output distance, output out_of_range, input ready);
    modport sink (input valid, input distance, input out_of_range, output ready);
endinterface

@@ sv/mdm_cfg_if.sv @@
interface mdm_cfg_if
    import mdm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/mdm_ctrl.sv @@
module mdm_ctrl
    import mdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [KIND_W-1:0] item_kind,
    input  mdm_status_t       status,
    output logic              item_ready,
    output mdm_cmd_t          cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        item_ready = 1'b0;
        cmd.accept = 1'b0;
        cmd.step = 1'b0;
        cmd.mode = SW_FILL;
        cmd.read = 1'b0;
        cmd.load = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.step = 1'b1;
                cmd.mode = SW_INIT;
                if (status.last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (item_kind)
                        KIND_CLEAR:
                        begin
                            if (!status.grid_empty)
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        KIND_PLACE:
                        begin
                            if (status.in_grid)
                            begin
                                state_next = ST_PLACE;
                            end
                        end
                        KIND_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.step = 1'b1;
                cmd.mode = SW_FILL;
                if (status.last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                cmd.step = 1'b1;
                cmd.mode = SW_PLACE;
                if (status.last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/mdm_datapath.sv @@
module mdm_datapath
    import mdm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mdm_cmd_t          cmd,
    input  logic [CFG_W-1:0]  grid_width,
    input  logic [CFG_W-1:0]  grid_height,
    input  logic [COL_W-1:0]  item_col,
    input  logic [ROW_W-1:0]  item_row,
    input  logic              result_ready,
    output logic              result_valid,
    output logic [DIST_W-1:0] result_distance,
    output logic              result_out_of_range,
    output mdm_status_t       status
);

    logic [DIST_W-1:0] mem [DEPTH];

    logic [DIM_W-1:0]  w_used;
    logic [DIM_W-1:0]  h_used;
    logic [DIM_W-1:0]  sweep_w;
    logic [DIM_W-1:0]  sweep_h;
    logic [DIST_W-1:0] clear_fill;

    logic [DIM_W-1:0]  c_reg;
    logic [DIM_W-1:0]  c_next;
    logic [DIM_W-1:0]  r_reg;
    logic [DIM_W-1:0]  r_next;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] base_next;
    logic [ADDR_W-1:0] sweep_addr;
    logic              row_end;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] item_addr;
    logic              read_inside;

    logic [DIM_W-1:0]  dc;
    logic [DIM_W-1:0]  dr;
    logic [DIM_W-1:0]  col_ext;
    logic [DIM_W-1:0]  row_ext;
    logic [DIST_W-1:0] d_next;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [DIST_W-1:0] s1_dist_reg;
    logic [DIST_W-1:0] rd_data_reg;
    logic              oor_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [DIST_W-1:0] mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    logic              res_valid_reg;
    logic [DIST_W-1:0] res_distance_reg;
    logic              res_oor_reg;

    assign w_used = used_dim(grid_width, MAX_COLS);
    assign h_used = used_dim(grid_height, MAX_ROWS);
    assign clear_fill = fill_value(w_used, h_used);
    assign sweep_w = (cmd.mode == SW_INIT) ? DIM_W'(MAX_COLS) : w_used;
    assign sweep_h = (cmd.mode == SW_INIT) ? DIM_W'(MAX_ROWS) : h_used;

    assign row_end = (c_reg == sweep_w - DIM_W'(1));
    assign sweep_addr = base_reg + ADDR_W'(c_reg);

    assign status.grid_empty = (w_used == '0) || (h_used == '0);
    assign status.in_grid = (32'(item_col) < 32'(w_used)) && (32'(item_row) < 32'(h_used));
    assign status.last_cell = row_end && (r_reg == sweep_h - DIM_W'(1));
    assign status.out_free = !res_valid_reg || result_ready;

    assign read_inside = (32'(col_reg) < 32'(w_used)) && (32'(row_reg) < 32'(h_used));
    assign item_addr = ADDR_W'(32'(row_reg) * MAX_COLS + 32'(col_reg));

    always_comb
    begin
        c_next = c_reg;
        r_next = r_reg;
        base_next = base_reg;
        if (cmd.step)
        begin
            if (status.last_cell)
            begin
                c_next = '0;
                r_next = '0;
                base_next = '0;
            end
            else if (row_end)
            begin
                c_next = '0;
                r_next = r_reg + DIM_W'(1);
                base_next = base_reg + ADDR_W'(MAX_COLS);
            end
            else
            begin
                c_next = c_reg + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
            r_reg <= '0;
            base_reg <= '0;
            s1_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            c_reg <= c_next;
            r_reg <= r_next;
            base_reg <= base_next;
            s1_valid_reg <= cmd.step && (cmd.mode == SW_PLACE);
            if (cmd.load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign col_ext = DIM_W'(col_reg);
    assign row_ext = DIM_W'(row_reg);
    assign dc = (c_reg >= col_ext) ? (c_reg - col_ext) : (col_ext - c_reg);
    assign dr = (r_reg >= row_ext) ? (r_reg - row_ext) : (row_ext - r_reg);
    assign d_next = DIST_W'(dc) + DIST_W'(dr);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_reg <= item_col;
            row_reg <= item_row;
        end
        s1_addr_reg <= sweep_addr;
        s1_dist_reg <= d_next;
        if (cmd.read)
        begin
            oor_reg <= !read_inside;
        end
        if (cmd.load)
        begin
            res_distance_reg <= oor_reg ? '0 : rd_data_reg;
            res_oor_reg <= oor_reg;
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = sweep_addr;
        mem_wd = clear_fill;
        mem_re = 1'b0;
        mem_ra = sweep_addr;
        if (cmd.step)
        begin
            unique case (cmd.mode)
                SW_INIT:
                begin
                    mem_we = 1'b1;
                    mem_wd = RESET_FILL;
                end
                SW_FILL:
                begin
                    mem_we = 1'b1;
                end
                SW_PLACE:
                begin
                    mem_re = 1'b1;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
        if (cmd.read)
        begin
            mem_re = 1'b1;
            mem_ra = item_addr;
        end
        if (s1_valid_reg && (s1_dist_reg < rd_data_reg))
        begin
            mem_we = 1'b1;
            mem_wa = s1_addr_reg;
            mem_wd = s1_dist_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign result_valid = res_valid_reg;
    assign result_distance = res_distance_reg;
    assign result_out_of_range = res_oor_reg;

endmodule

@@ sv/manhattan_distance_map.sv @@
// Distance map over a grid of up to 64 by 64 cells held in a 4096-entry single-write-port
// memory that is visited one cell per clock. A clear request sweeps every cell of the grid
// and a place request inside the grid does the same; an empty grid, a place outside the
// grid or an unused kind is taken without a sweep. A read request registers the memory word
// and then loads it into the result register, and the next request is accepted while that
// result waits to be taken. After reset the block fills the whole memory with the reset
// clear value and accepts no request meanwhile; configuration writes are taken at any time.
module manhattan_distance_map
    import mdm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    mdm_cfg_if.sink        cfg,
    mdm_item_if.sink       item,
    mdm_result_if.source   result
);

    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_height_reg;
    mdm_cmd_t         cmd;
    mdm_status_t      status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_GRID_WIDTH:
                begin
                    grid_width_reg <= cfg.data;
                end
                REG_GRID_HEIGHT:
                begin
                    grid_height_reg <= cfg.data;
                end
                default:
                begin
                    grid_width_reg <= grid_width_reg;
                end
            endcase
        end
    end

    mdm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_kind  (item.kind),
        .status     (status),
        .item_ready (item.ready),
        .cmd        (cmd)
    );

    mdm_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .grid_width          (grid_width_reg),
        .grid_height         (grid_height_reg),
        .item_col            (item.col),
        .item_row            (item.row),
        .result_ready        (result.ready),
        .result_valid        (result.valid),
        .result_distance     (result.distance),
        .result_out_of_range (result.out_of_range),
        .status              (status)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready && (item.kind == KIND_READ) |=> !item.ready)
        else $error("Request accepted straight after a read request.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.load))
        else $error("Result appeared without being loaded.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !item.ready)
        else $error("Request accepted during a memory sweep.");
`endif

endmodule
